// ===== sv/deletion_window_compaction_trigger_top_macros.svh =====
// assertion macros for the deletion window compaction trigger checker
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef DELETION_WINDOW_COMPACTION_TRIGGER_TOP_MACROS_SVH
`define DELETION_WINDOW_COMPACTION_TRIGGER_TOP_MACROS_SVH

// same-cycle implication, masked while reset is low
`define DWCT_CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dwct check failed");

// next-cycle implication, masked while reset is low
`define DWCT_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dwct check failed");

// next-cycle consequence of reset itself
`define DWCT_CHK_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("dwct reset check failed");

`endif

// ===== sv/dwct_pkg.sv =====
// shared types, widths and codes for the deletion window compaction trigger
// no dependencies
package dwct_pkg;

    localparam int LEN_W     = 13;
    localparam int FS_W      = 48;
    localparam int TYPE_W    = 3;
    localparam int KEY_W     = 16;
    localparam int NUM_TYPES = 5;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [TYPE_W-1:0] {
        ET_PUT           = 3'd0,
        ET_DELETE        = 3'd1,
        ET_SINGLE_DELETE = 3'd2,
        ET_MERGE         = 3'd3,
        ET_OTHER         = 3'd4
    } t_entry_type;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEN      = 2'd0,
        CFG_DELETE_LIMIT    = 2'd1,
        CFG_FILE_SIZE_LIMIT = 2'd2,
        CFG_COUNT_SINGLE    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_W-1:0] window_len;
        logic [LEN_W-1:0] delete_limit;
        logic [FS_W-1:0]  file_size_limit;
        logic             count_single_delete;
    } t_cfg;

    // window length clipped to the flag store depth
    function automatic logic [LEN_W-1:0] f_eff_len(input logic [LEN_W-1:0] wl,
                                                   input logic [31:0] wmax);
        logic [LEN_W-1:0] res;
        if (32'(wl) > wmax) begin
            res = LEN_W'(wmax);
        end else begin
            res = wl;
        end
        return res;
    endfunction

endpackage

// ===== sv/deletion_window_compaction_trigger_top.sv =====
// top level of the deletion window compaction trigger: configuration registers
// and the window and decision stages; uses dwct_pkg, dwct_window, dwct_decide
//
// Takes one key entry per cycle unless i_ready stalls the results; each entry
// yields one result, in order, via the flag read and window stages and decision
// stages A, B and C. The rate is set by the delete flag memory, whose single
// read-modify-write per cycle is kept back to back by write-first forwarding.
// After reset the flag memory is cleared one entry per cycle, so o_ready stays
// low until the sweep ends; configuration writes are taken meanwhile.
// Results wait in a registered pipeline; entries flow while stages hold bubbles.
module deletion_window_compaction_trigger_top #(
    parameter int WINDOW_MAX     = 4096,
    parameter int TOTAL_BITS     = 40,
    parameter int MIN_KEY_LENGTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dwct_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dwct_pkg::FS_W-1:0]          i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [dwct_pkg::TYPE_W-1:0]        i_entry_type,
    input  logic [dwct_pkg::KEY_W-1:0]         i_key_length,
    input  logic [dwct_pkg::FS_W-1:0]          i_file_size,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [dwct_pkg::LEN_W-1:0]         o_deleted_in_window,
    output logic [dwct_pkg::LEN_W-1:0]         o_max_deleted_in_window,
    output logic [dwct_pkg::FS_W-1:0]          o_largest_file_size,
    output logic                               o_need_compact
);

    dwct_pkg::t_cfg r_cfg;

    logic                                           win_valid;
    logic                                           dec_ready;
    logic [dwct_pkg::LEN_W-1:0]                     win_count;
    logic [dwct_pkg::LEN_W-1:0]                     win_peak;
    logic [dwct_pkg::FS_W-1:0]                      win_fpeak;
    logic [dwct_pkg::NUM_TYPES-1:0][TOTAL_BITS-1:0] win_totals;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dwct_pkg::CFG_WINDOW_LEN: begin
                    r_cfg.window_len <= i_cfg_data[dwct_pkg::LEN_W-1:0];
                end
                dwct_pkg::CFG_DELETE_LIMIT: begin
                    r_cfg.delete_limit <= i_cfg_data[dwct_pkg::LEN_W-1:0];
                end
                dwct_pkg::CFG_FILE_SIZE_LIMIT: begin
                    r_cfg.file_size_limit <= i_cfg_data;
                end
                dwct_pkg::CFG_COUNT_SINGLE: begin
                    r_cfg.count_single_delete <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    dwct_window #(
        .WINDOW_MAX     (WINDOW_MAX),
        .TOTAL_BITS     (TOTAL_BITS),
        .MIN_KEY_LENGTH (MIN_KEY_LENGTH)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_entry_type (i_entry_type),
        .i_key_length (i_key_length),
        .i_file_size  (i_file_size),
        .o_valid      (win_valid),
        .i_ready      (dec_ready),
        .o_count      (win_count),
        .o_peak       (win_peak),
        .o_fpeak      (win_fpeak),
        .o_totals     (win_totals)
    );

    dwct_decide #(
        .WINDOW_MAX (WINDOW_MAX),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_decide (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg                   (r_cfg),
        .i_valid                 (win_valid),
        .o_ready                 (dec_ready),
        .i_count                 (win_count),
        .i_peak                  (win_peak),
        .i_fpeak                 (win_fpeak),
        .i_totals                (win_totals),
        .o_valid                 (o_valid),
        .i_ready                 (i_ready),
        .o_deleted_in_window     (o_deleted_in_window),
        .o_max_deleted_in_window (o_max_deleted_in_window),
        .o_largest_file_size     (o_largest_file_size),
        .o_need_compact          (o_need_compact)
    );

endmodule

// ===== sv/dwct_flag_mem.sv =====
// one-bit-wide delete flag store with registered read and write-first forwarding
// clears itself after reset, one entry per cycle; uses nothing
module dwct_flag_mem #(
    parameter int WINDOW_MAX = 4096,
    parameter int AW         = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic          o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_data,
    output logic          o_clr_done
);

    logic          r_mem [WINDOW_MAX];
    logic          r_rd;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          we;
    logic [AW-1:0] wa;
    logic          wd;

    always_comb begin
        if (r_clr_busy) begin
            we = 1'b1;
            wa = r_clr_addr;
            wd = 1'b0;
        end else begin
            we = i_wr_en;
            wa = i_wr_addr;
            wd = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(WINDOW_MAX - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
    end

    // a write to the same entry in the read cycle wins
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd <= i_wr_data;
            end else begin
                r_rd <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data  = r_rd;
    assign o_clr_done = !r_clr_busy;

endmodule

// ===== sv/dwct_window.sv =====
// window front end: position tracking, flag read-modify-write, delete count,
// per-type totals and file size peak; uses dwct_pkg and dwct_flag_mem
module dwct_window #(
    parameter int WINDOW_MAX     = 4096,
    parameter int TOTAL_BITS     = 40,
    parameter int MIN_KEY_LENGTH = 4
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  dwct_pkg::t_cfg                                         i_cfg,
    input  logic                                                   i_valid,
    output logic                                                   o_ready,
    input  logic [dwct_pkg::TYPE_W-1:0]                            i_entry_type,
    input  logic [dwct_pkg::KEY_W-1:0]                             i_key_length,
    input  logic [dwct_pkg::FS_W-1:0]                              i_file_size,
    output logic                                                   o_valid,
    input  logic                                                   i_ready,
    output logic [dwct_pkg::LEN_W-1:0]                             o_count,
    output logic [dwct_pkg::LEN_W-1:0]                             o_peak,
    output logic [dwct_pkg::FS_W-1:0]                              o_fpeak,
    output logic [dwct_pkg::NUM_TYPES-1:0][TOTAL_BITS-1:0]         o_totals
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = ((AW > dwct_pkg::LEN_W) ? AW : dwct_pkg::LEN_W) + 1;

    // stage 1: flag read in flight
    logic                          r_v1;
    logic                          r_s1_key_ok;
    logic                          r_s1_track;
    logic                          r_s1_del;
    logic [AW-1:0]                 r_s1_addr;
    logic [dwct_pkg::TYPE_W-1:0]   r_s1_slot;
    logic [dwct_pkg::FS_W-1:0]     r_s1_fsize;

    // architectural state, doubles as stage 2 payload
    logic                                           r_v2;
    logic [AW-1:0]                                  r_pos;
    logic [dwct_pkg::LEN_W-1:0]                     r_count;
    logic [dwct_pkg::LEN_W-1:0]                     r_peak;
    logic [dwct_pkg::FS_W-1:0]                      r_fpeak;
    logic [dwct_pkg::NUM_TYPES-1:0][TOTAL_BITS-1:0] r_totals;

    logic [dwct_pkg::LEN_W-1:0]                     n_count;
    logic [dwct_pkg::LEN_W-1:0]                     n_peak;
    logic [dwct_pkg::FS_W-1:0]                      n_fpeak;
    logic [dwct_pkg::NUM_TYPES-1:0][TOTAL_BITS-1:0] n_totals;
    logic [AW-1:0]                                  n_pos;

    logic                          clr_done;
    logic                          acc;
    logic                          adv1;
    logic                          key_ok;
    logic                          is_del;
    logic [dwct_pkg::TYPE_W-1:0]   slot;
    logic [dwct_pkg::LEN_W-1:0]    len;
    logic [CW-1:0]                 len_ext;
    logic [AW-1:0]                 pos_eff;
    logic [CW-1:0]                 pos_inc;
    logic                          old_flag;
    logic                          wr_en;

    assign adv1    = r_v1 && (!r_v2 || i_ready);
    assign o_ready = clr_done && (!r_v1 || adv1);
    assign acc     = i_valid && o_ready;

    assign len     = dwct_pkg::f_eff_len(i_cfg.window_len, 32'(WINDOW_MAX));
    assign len_ext = CW'(len);
    assign key_ok  = i_key_length >= dwct_pkg::KEY_W'(MIN_KEY_LENGTH);
    assign is_del  = (i_entry_type == dwct_pkg::ET_DELETE) ||
                     ((i_entry_type == dwct_pkg::ET_SINGLE_DELETE) &&
                      i_cfg.count_single_delete);
    // unknown codes fold into the last bucket
    assign slot    = (i_entry_type > dwct_pkg::ET_OTHER) ? dwct_pkg::ET_OTHER : i_entry_type;

    always_comb begin
        if (CW'(r_pos) >= len_ext) begin
            pos_eff = '0;
        end else begin
            pos_eff = r_pos;
        end
        pos_inc = CW'(pos_eff) + CW'(1);
        if (pos_inc >= len_ext) begin
            n_pos = '0;
        end else begin
            n_pos = pos_inc[AW-1:0];
        end
    end

    assign wr_en = adv1 && r_s1_key_ok && r_s1_track;

    dwct_flag_mem #(
        .WINDOW_MAX (WINDOW_MAX),
        .AW         (AW)
    ) u_flag_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (acc),
        .i_rd_addr  (pos_eff),
        .o_rd_data  (old_flag),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_s1_addr),
        .i_wr_data  (r_s1_del),
        .o_clr_done (clr_done)
    );

    always_comb begin
        n_count  = r_count;
        n_peak   = r_peak;
        n_fpeak  = r_fpeak;
        n_totals = r_totals;
        if (r_s1_key_ok) begin
            if (r_s1_track && (old_flag != r_s1_del)) begin
                if (!r_s1_del) begin
                    if (r_count != '0) begin
                        n_count = r_count - dwct_pkg::LEN_W'(1);
                    end
                end else begin
                    if (r_count != {dwct_pkg::LEN_W{1'b1}}) begin
                        n_count = r_count + dwct_pkg::LEN_W'(1);
                    end
                    if (n_count > r_peak) begin
                        n_peak = n_count;
                    end
                end
            end
            for (int i = 0; i < dwct_pkg::NUM_TYPES; i++) begin
                if ((r_s1_slot == dwct_pkg::TYPE_W'(i)) &&
                    (r_totals[i] != {TOTAL_BITS{1'b1}})) begin
                    n_totals[i] = r_totals[i] + TOTAL_BITS'(1);
                end
            end
            if (r_s1_fsize > r_fpeak) begin
                n_fpeak = r_s1_fsize;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_pos    <= '0;
            r_count  <= '0;
            r_peak   <= '0;
            r_fpeak  <= '0;
            r_totals <= '0;
        end else begin
            if (acc) begin
                r_v1 <= 1'b1;
                if (key_ok && (len != '0)) begin
                    r_pos <= n_pos;
                end
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv1) begin
                r_v2     <= 1'b1;
                r_count  <= n_count;
                r_peak   <= n_peak;
                r_fpeak  <= n_fpeak;
                r_totals <= n_totals;
            end else if (i_ready) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_key_ok <= key_ok;
            r_s1_track  <= len != '0;
            r_s1_del    <= is_del;
            r_s1_addr   <= pos_eff;
            r_s1_slot   <= slot;
            r_s1_fsize  <= i_file_size;
        end
    end

    assign o_valid  = r_v2;
    assign o_count  = r_count;
    assign o_peak   = r_peak;
    assign o_fpeak  = r_fpeak;
    assign o_totals = r_totals;

endmodule

// ===== sv/dwct_decide.sv =====
// compaction decision pipeline: totals sum, cross-multiplied fraction test,
// registered result; uses dwct_pkg
module dwct_decide #(
    parameter int WINDOW_MAX = 4096,
    parameter int TOTAL_BITS = 40
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  dwct_pkg::t_cfg                                 i_cfg,
    input  logic                                           i_valid,
    output logic                                           o_ready,
    input  logic [dwct_pkg::LEN_W-1:0]                     i_count,
    input  logic [dwct_pkg::LEN_W-1:0]                     i_peak,
    input  logic [dwct_pkg::FS_W-1:0]                      i_fpeak,
    input  logic [dwct_pkg::NUM_TYPES-1:0][TOTAL_BITS-1:0] i_totals,
    output logic                                           o_valid,
    input  logic                                           i_ready,
    output logic [dwct_pkg::LEN_W-1:0]                     o_deleted_in_window,
    output logic [dwct_pkg::LEN_W-1:0]                     o_max_deleted_in_window,
    output logic [dwct_pkg::FS_W-1:0]                      o_largest_file_size,
    output logic                                           o_need_compact
);

    localparam int EW  = TOTAL_BITS + 3;
    localparam int DW  = TOTAL_BITS + 1;
    localparam int PRW = EW + dwct_pkg::LEN_W;
    localparam int PLW = DW + dwct_pkg::LEN_W;

    logic                          r_va;
    logic [dwct_pkg::LEN_W-1:0]    r_a_count;
    logic [dwct_pkg::LEN_W-1:0]    r_a_peak;
    logic [dwct_pkg::FS_W-1:0]     r_a_fpeak;
    logic [EW-1:0]                 r_a_ent;
    logic [DW-1:0]                 r_a_del;
    logic                          r_a_gate;
    logic                          r_a_over;

    logic                          r_vb;
    logic [dwct_pkg::LEN_W-1:0]    r_b_count;
    logic [dwct_pkg::LEN_W-1:0]    r_b_peak;
    logic [dwct_pkg::FS_W-1:0]     r_b_fpeak;
    logic [PLW-1:0]                r_b_lhs;
    logic [PRW-1:0]                r_b_rhs;
    logic                          r_b_gate;
    logic                          r_b_over;
    logic                          r_b_ent_nz;

    logic                          r_vc;
    logic [dwct_pkg::LEN_W-1:0]    r_c_count;
    logic [dwct_pkg::LEN_W-1:0]    r_c_peak;
    logic [dwct_pkg::FS_W-1:0]     r_c_fpeak;
    logic                          r_c_need;

    logic                          rdy_a;
    logic                          rdy_b;
    logic                          rdy_c;
    logic                          ld_a;
    logic                          ld_b;
    logic                          ld_c;
    logic [dwct_pkg::LEN_W-1:0]    len;
    logic [EW-1:0]                 ent_sum;
    logic [DW-1:0]                 del_sum;
    logic                          gate;

    assign rdy_c   = !r_vc || i_ready;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign ld_a    = i_valid && rdy_a;
    assign ld_b    = r_va && rdy_b;
    assign ld_c    = r_vb && rdy_c;

    assign len = dwct_pkg::f_eff_len(i_cfg.window_len, 32'(WINDOW_MAX));

    always_comb begin
        ent_sum = '0;
        for (int i = 0; i < dwct_pkg::NUM_TYPES; i++) begin
            ent_sum = ent_sum + EW'(i_totals[i]);
        end
        del_sum = DW'(i_totals[dwct_pkg::ET_DELETE]);
        if (i_cfg.count_single_delete) begin
            del_sum = del_sum + DW'(i_totals[dwct_pkg::ET_SINGLE_DELETE]);
        end
        gate = (i_cfg.delete_limit != '0) && (len != '0) &&
               (i_fpeak > i_cfg.file_size_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (ld_a) begin
                r_va <= 1'b1;
            end else if (rdy_b) begin
                r_va <= 1'b0;
            end
            if (ld_b) begin
                r_vb <= 1'b1;
            end else if (rdy_c) begin
                r_vb <= 1'b0;
            end
            if (ld_c) begin
                r_vc <= 1'b1;
            end else if (i_ready) begin
                r_vc <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_a) begin
            r_a_count <= i_count;
            r_a_peak  <= i_peak;
            r_a_fpeak <= i_fpeak;
            r_a_ent   <= ent_sum;
            r_a_del   <= del_sum;
            r_a_gate  <= gate;
            r_a_over  <= i_peak > i_cfg.delete_limit;
        end
        if (ld_b) begin
            r_b_count  <= r_a_count;
            r_b_peak   <= r_a_peak;
            r_b_fpeak  <= r_a_fpeak;
            r_b_lhs    <= PLW'(r_a_del) * PLW'(len);
            r_b_rhs    <= PRW'(r_a_ent) * PRW'(i_cfg.delete_limit);
            r_b_gate   <= r_a_gate;
            r_b_over   <= r_a_over;
            r_b_ent_nz <= r_a_ent != '0;
        end
        if (ld_c) begin
            r_c_count <= r_b_count;
            r_c_peak  <= r_b_peak;
            r_c_fpeak <= r_b_fpeak;
            r_c_need  <= r_b_gate &&
                         (r_b_over || (r_b_ent_nz && (PRW'(r_b_lhs) > r_b_rhs)));
        end
    end

    assign o_valid                 = r_vc;
    assign o_deleted_in_window     = r_c_count;
    assign o_max_deleted_in_window = r_c_peak;
    assign o_largest_file_size     = r_c_fpeak;
    assign o_need_compact          = r_c_need;

endmodule

// ===== sv/dwct_checker.sv =====
// port-level checker for the deletion window compaction trigger, bound to the top
// uses dwct_pkg and deletion_window_compaction_trigger_top_macros.svh
`include "deletion_window_compaction_trigger_top_macros.svh"

module dwct_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_ready,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [dwct_pkg::LEN_W-1:0]     o_deleted_in_window,
    input logic [dwct_pkg::LEN_W-1:0]     o_max_deleted_in_window,
    input logic [dwct_pkg::FS_W-1:0]      o_largest_file_size,
    input logic                           o_need_compact
);

    logic [2*dwct_pkg::LEN_W+dwct_pkg::FS_W:0] out_word;

    assign out_word = {o_deleted_in_window, o_max_deleted_in_window,
                       o_largest_file_size, o_need_compact};

    // a stalled result transaction stays offered
    `DWCT_CHK_NEXT(a_out_hold, o_valid && !i_ready, o_valid)

    // and keeps its payload
    `DWCT_CHK_NEXT(a_out_stable, o_valid && !i_ready, $stable(out_word))

    // the peak never trails the live count
    `DWCT_CHK_NOW(a_peak_ge_count, o_valid, o_max_deleted_in_window >= o_deleted_in_window)

    // the flag clearing sweep blocks input right after reset
    `DWCT_CHK_RST(a_clear_blocks, !o_ready)

endmodule

bind deletion_window_compaction_trigger_top dwct_checker u_dwct_checker (.*);

// ===== tb/deletion_window_compaction_trigger_top_test.sv =====
// testbench for deletion_window_compaction_trigger_top: random and directed key entries
// checked in order against a scoreboard that tracks the delete window and trigger rule
// depends on dwct_pkg and the top level rtl
module deletion_window_compaction_trigger_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_MAX  = 4096;
    localparam int MIN_KEY     = 4;
    localparam int LATENCY     = 4;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [dwct_pkg::TYPE_W-1:0] ET_SPARE_FIRST =
        dwct_pkg::TYPE_W'(dwct_pkg::ET_OTHER) + 3'd1;
    localparam logic [dwct_pkg::TYPE_W-1:0] ET_SPARE_LAST  = '1;
    localparam logic [dwct_pkg::FS_W-1:0]   SIZE_TOP       = '1;
    localparam logic [dwct_pkg::LEN_W-1:0]  LEN_TOP        = '1;
    localparam logic [dwct_pkg::KEY_W-1:0]  KEY_TOP        = '1;

    class trigger_scoreboard;
        typedef struct packed {
            bit [dwct_pkg::LEN_W-1:0] in_window;
            bit [dwct_pkg::LEN_W-1:0] peak;
            bit [dwct_pkg::FS_W-1:0]  largest;
            bit                       compact;
        } t_status;

        localparam int FLAG_DEPTH = 4096;
        localparam bit [dwct_pkg::LEN_W-1:0] COUNT_TOP = '1;
        localparam bit [39:0] TOTAL_TOP = '1;

        bit [dwct_pkg::LEN_W-1:0] win_len;
        bit [dwct_pkg::LEN_W-1:0] del_limit;
        bit [dwct_pkg::FS_W-1:0]  size_limit;
        bit                       count_single;

        bit                       flags [FLAG_DEPTH];
        int unsigned              head;
        bit [dwct_pkg::LEN_W-1:0] win_count;
        bit [dwct_pkg::LEN_W-1:0] win_peak;
        bit [39:0]                totals [dwct_pkg::NUM_TYPES];
        bit [dwct_pkg::FS_W-1:0]  size_peak;

        t_status        status_due [$];
        int             errors;

        function new();
            win_len = '0;
            del_limit = '0;
            size_limit = '0;
            count_single = 1'b0;
            foreach (flags[i]) flags[i] = 1'b0;
            head = 0;
            win_count = '0;
            win_peak = '0;
            foreach (totals[i]) totals[i] = '0;
            size_peak = '0;
            errors = 0;
        endfunction

        function void write_reg(dwct_pkg::t_cfg_idx idx, bit [dwct_pkg::FS_W-1:0] data);
            case (idx)
                dwct_pkg::CFG_WINDOW_LEN:      win_len = data[dwct_pkg::LEN_W-1:0];
                dwct_pkg::CFG_DELETE_LIMIT:    del_limit = data[dwct_pkg::LEN_W-1:0];
                dwct_pkg::CFG_FILE_SIZE_LIMIT: size_limit = data;
                dwct_pkg::CFG_COUNT_SINGLE:    count_single = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned span();
            return (win_len > FLAG_DEPTH) ? FLAG_DEPTH : int'(win_len);
        endfunction

        // fraction test done by cross multiplication, no division
        function bit compaction_due();
            int unsigned len;
            bit [42:0]   entries;
            bit [41:0]   dels;
            bit [63:0]   lhs;
            bit [63:0]   rhs;
            len = span();
            if (del_limit == 0 || len == 0 || size_peak <= size_limit) return 1'b0;
            if (win_peak > del_limit) return 1'b1;
            entries = '0;
            foreach (totals[i]) entries += 43'(totals[i]);
            if (entries == 0) return 1'b0;
            dels = 42'(totals[dwct_pkg::ET_DELETE]);
            if (count_single) dels += 42'(totals[dwct_pkg::ET_SINGLE_DELETE]);
            lhs = 64'(dels) * 64'(len);
            rhs = 64'(entries) * 64'(del_limit);
            return lhs > rhs;
        endfunction

        function void advance_window(bit [dwct_pkg::TYPE_W-1:0] etype,
                                     bit [dwct_pkg::KEY_W-1:0] klen,
                                     bit [dwct_pkg::FS_W-1:0] fsize);
            int unsigned len;
            int unsigned pos;
            int unsigned slot;
            bit          is_del;
            t_status     st;
            if (klen >= MIN_KEY) begin
                len = span();
                if (len > 0) begin
                    is_del = (etype == dwct_pkg::ET_DELETE) ||
                             (etype == dwct_pkg::ET_SINGLE_DELETE && count_single);
                    // a shrunk window wraps the position before use
                    pos = (head >= len) ? 0 : head;
                    if (flags[pos] != is_del) begin
                        flags[pos] = is_del;
                        if (!is_del) begin
                            if (win_count > 0) win_count--;
                        end else begin
                            if (win_count < COUNT_TOP) win_count++;
                            if (win_count > win_peak) win_peak = win_count;
                        end
                    end
                    pos++;
                    if (pos >= len) pos = 0;
                    head = pos;
                end
                slot = (etype < dwct_pkg::NUM_TYPES) ? int'(etype) : dwct_pkg::NUM_TYPES - 1;
                if (totals[slot] != TOTAL_TOP) totals[slot]++;
                if (fsize > size_peak) size_peak = fsize;
            end
            st.in_window = win_count;
            st.peak = win_peak;
            st.largest = size_peak;
            st.compact = compaction_due();
            status_due = {status_due, st};
        endfunction

        function int pending();
            return status_due.size();
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            $display("ERROR %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_status(bit [dwct_pkg::LEN_W-1:0] in_window, bit [dwct_pkg::LEN_W-1:0] peak,
                          bit [dwct_pkg::FS_W-1:0] largest, bit compact);
            t_status want;
            if (status_due.size() == 0) begin
                report("result with no entry outstanding", in_window, 0);
            end else begin
                want = status_due.pop_front();
                if (in_window != want.in_window)
                    report("deleted_in_window", in_window, want.in_window);
                if (peak != want.peak)
                    report("max_deleted_in_window", peak, want.peak);
                if (largest != want.largest)
                    report("largest_file_size", largest, want.largest);
                if (compact != want.compact)
                    report("need_compact", compact, want.compact);
            end
        endtask

        task check_drained();
            if (status_due.size() != 0)
                report("results never returned", 0, status_due.size());
        endtask
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [dwct_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [dwct_pkg::FS_W-1:0]      i_cfg_data = '0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic [dwct_pkg::TYPE_W-1:0]    i_entry_type = '0;
    logic [dwct_pkg::KEY_W-1:0]     i_key_length = '0;
    logic [dwct_pkg::FS_W-1:0]      i_file_size = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [dwct_pkg::LEN_W-1:0]     o_deleted_in_window;
    logic [dwct_pkg::LEN_W-1:0]     o_max_deleted_in_window;
    logic [dwct_pkg::FS_W-1:0]      o_largest_file_size;
    logic                           o_need_compact;

    bit                   steady = 1'b0;
    int                   cycle_count = 0;
    trigger_scoreboard    sb;

    deletion_window_compaction_trigger_top u_top (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_idx               (i_cfg_idx),
        .i_cfg_data              (i_cfg_data),
        .i_valid                 (i_valid),
        .o_ready                 (o_ready),
        .i_entry_type            (i_entry_type),
        .i_key_length            (i_key_length),
        .i_file_size             (i_file_size),
        .o_valid                 (o_valid),
        .i_ready                 (i_ready),
        .o_deleted_in_window     (o_deleted_in_window),
        .o_max_deleted_in_window (o_max_deleted_in_window),
        .o_largest_file_size     (o_largest_file_size),
        .o_need_compact          (o_need_compact)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= 32);
    end

    // samples pre-edge values, so ordering against the rtl does not matter
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_reg(dwct_pkg::t_cfg_idx'(i_cfg_idx), i_cfg_data);
            if (i_valid && o_ready)
                sb.advance_window(i_entry_type, i_key_length, i_file_size);
            if (o_valid && i_ready)
                sb.check_status(o_deleted_in_window, o_max_deleted_in_window,
                                o_largest_file_size, o_need_compact);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic write_reg(dwct_pkg::t_cfg_idx idx, logic [dwct_pkg::FS_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // noise lands in data bits above each register's width
    task automatic configure(int unsigned wl, int unsigned dl,
                             longint unsigned fsl, logic csd, bit noisy);
        logic [dwct_pkg::FS_W-1:0] noise;
        noise = noisy ? dwct_pkg::FS_W'({$urandom, $urandom}) : '0;
        write_reg(dwct_pkg::CFG_WINDOW_LEN,
                  (noise & ~dwct_pkg::FS_W'(LEN_TOP)) | dwct_pkg::FS_W'(wl));
        write_reg(dwct_pkg::CFG_DELETE_LIMIT,
                  (noise & ~dwct_pkg::FS_W'(LEN_TOP)) | dwct_pkg::FS_W'(dl));
        write_reg(dwct_pkg::CFG_FILE_SIZE_LIMIT, dwct_pkg::FS_W'(fsl));
        write_reg(dwct_pkg::CFG_COUNT_SINGLE,
                  (noise & ~dwct_pkg::FS_W'(1)) | dwct_pkg::FS_W'(csd));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_entry(logic [dwct_pkg::TYPE_W-1:0] etype, int unsigned klen,
                              longint unsigned fsize);
        if (!steady && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while (!steady && $urandom_range(99) < 32);
        end
        i_valid <= 1'b1;
        i_entry_type <= etype;
        i_key_length <= dwct_pkg::KEY_W'(klen);
        i_file_size <= dwct_pkg::FS_W'(fsize);
        do @(posedge i_clk); while (!o_ready);
    endtask

    // negedge polling keeps clear of the monitor at the accepting edge
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int                          taken;
        int                          n_items;
        int                          del_pct;
        int                          size_bits;
        logic [dwct_pkg::TYPE_W-1:0] et;
        logic [dwct_pkg::KEY_W-1:0]  kl;
        logic [dwct_pkg::FS_W-1:0]   fs;
        logic [dwct_pkg::FS_W-1:0]   size_mask;
        int unsigned                 wl;
        int unsigned                 dl;
        longint unsigned             fsl;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every type, spare codes, short keys, then a full window of deletes
        configure(4, 1, 0, 1'b1, 1'b0);
        send_entry(dwct_pkg::ET_PUT, MIN_KEY, 0);
        send_entry(dwct_pkg::ET_DELETE, KEY_TOP, 1);
        send_entry(dwct_pkg::ET_SINGLE_DELETE, MIN_KEY, 100);
        send_entry(dwct_pkg::ET_MERGE, 16, 7);
        send_entry(dwct_pkg::ET_OTHER, 8, 5);
        send_entry(ET_SPARE_FIRST, 8, 9);
        send_entry(ET_SPARE_LAST, 8, 3);
        send_entry(dwct_pkg::ET_DELETE, 0, 500);
        send_entry(dwct_pkg::ET_DELETE, MIN_KEY - 1, 600);
        repeat (4) send_entry(dwct_pkg::ET_DELETE, 5, 50);
        wait_idle();

        // shrink the window below the current position, limit never exceeded
        configure(2, WINDOW_MAX, SIZE_TOP, 1'b0, 1'b1);
        send_entry(dwct_pkg::ET_DELETE, MIN_KEY, 1000);
        send_entry(dwct_pkg::ET_SINGLE_DELETE, MIN_KEY, 1000);
        send_entry(dwct_pkg::ET_PUT, MIN_KEY, 2000);
        send_entry(dwct_pkg::ET_PUT, MIN_KEY, 0);
        wait_idle();

        // window length past the store depth
        configure(LEN_TOP, LEN_TOP, 100, 1'b1, 1'b0);
        repeat (3) send_entry(dwct_pkg::ET_SINGLE_DELETE, MIN_KEY, 300);
        send_entry(dwct_pkg::ET_DELETE, MIN_KEY, 400);
        wait_idle();

        // tracking disabled
        configure(0, 0, 0, 1'b0, 1'b0);
        send_entry(dwct_pkg::ET_DELETE, MIN_KEY, 10);
        send_entry(dwct_pkg::ET_PUT, MIN_KEY, 20);
        wait_idle();

        for (int ph = 0; ph < 12; ph++) begin
            size_bits = (16 + 3 * ph > dwct_pkg::FS_W) ? dwct_pkg::FS_W : 16 + 3 * ph;
            size_mask = SIZE_TOP >> (dwct_pkg::FS_W - size_bits);
            case ($urandom_range(7))
                0: wl = 0;
                1: wl = 1;
                2: wl = WINDOW_MAX;
                3: wl = LEN_TOP;
                4: wl = dwct_pkg::LEN_W'($urandom_range(8191));
                default: wl = dwct_pkg::LEN_W'($urandom_range(64, 2));
            endcase
            case ($urandom_range(5))
                0: dl = 0;
                1: dl = 1;
                2: dl = LEN_TOP;
                3: dl = dwct_pkg::LEN_W'($urandom_range(8191));
                default: dl = dwct_pkg::LEN_W'($urandom_range(32, 1));
            endcase
            case ($urandom_range(3))
                0: fsl = 0;
                1: fsl = SIZE_TOP;
                2: fsl = dwct_pkg::FS_W'({$urandom, $urandom}) & size_mask;
                default: fsl = dwct_pkg::FS_W'($urandom_range(1000));
            endcase
            del_pct = $urandom_range(90, 10);
            n_items = 80;
            if (ph == 2) begin
                wl = dwct_pkg::LEN_W'($urandom_range(64, 8));
                n_items = 300;
            end
            if (ph == 6) begin
                wl = WINDOW_MAX;
                del_pct = 90;
            end
            if (ph == 7) wl = LEN_TOP;
            steady = (ph == 4);
            configure(wl, dl, fsl, 1'($urandom_range(1)), 1'($urandom_range(1)));
            taken = 0;
            while (taken < n_items) begin
                if ($urandom_range(99) < del_pct)
                    et = $urandom_range(1) ? dwct_pkg::ET_DELETE : dwct_pkg::ET_SINGLE_DELETE;
                else
                    et = dwct_pkg::TYPE_W'($urandom_range(7));
                case ($urandom_range(99)) inside
                    [0:7]:   kl = dwct_pkg::KEY_W'($urandom_range(MIN_KEY - 1));
                    [8:53]:  kl = dwct_pkg::KEY_W'($urandom_range(64, MIN_KEY));
                    default: kl = dwct_pkg::KEY_W'($urandom_range(65535, MIN_KEY));
                endcase
                fs = dwct_pkg::FS_W'({$urandom, $urandom}) & size_mask;
                if (kl >= MIN_KEY) taken++;
                send_entry(et, kl, fs);
            end
            wait_idle();
        end
        steady = 1'b0;

        // largest file size last, since the peak holds it from then on
        send_entry(dwct_pkg::ET_DELETE, KEY_TOP, SIZE_TOP);
        wait_idle();
        repeat (4 * LATENCY) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
